// ===== rtl/ipv4_longest_prefix_trie_macros.svh =====
// assertion macros for the prefix trie block
// used by the top level only, no other dependencies
`ifndef IPV4_LONGEST_PREFIX_TRIE_MACROS_SVH
`define IPV4_LONGEST_PREFIX_TRIE_MACROS_SVH
`ifndef SYNTHESIS
`define LPT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPT_ASSERT(lbl, prop, msg) `LPT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define LPT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define LPT_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== rtl/lpt_pkg.sv =====
// shared constants, types and codes for the prefix trie block
// no dependencies
package lpt_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int ADDR_BITS  = 32;

  localparam int ADDR_W     = 32;
  localparam int AIDX_W     = $clog2(ADDR_W);
  localparam int LEN_W      = 6;
  localparam int HOP_W      = 16;
  localparam int NODE_IDX_W = $clog2(NODE_COUNT);
  localparam int NODE_CNT_W = $clog2(NODE_COUNT + 1);
  localparam int LVL_W      = $clog2(ADDR_BITS + 1);
  localparam int SUM_W      = NODE_CNT_W + 1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [NODE_IDX_W-1:0] left;
    logic [NODE_IDX_W-1:0] right;
    logic                  mark;
    logic [HOP_W-1:0]      hop;
  } node_t;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
    logic [HOP_W-1:0]  next_hop;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [HOP_W-1:0] hop_out;
  } rsp_t;

  typedef struct packed {
    logic                  bit_sel;
    logic [NODE_IDX_W-1:0] child;
    logic                  no_child;
    logic                  full;
  } step_t;

endpackage

// ===== rtl/lpt_node_ram.sv =====
// node pool memory, one write port and one registered read port
// depends on lpt_pkg for the node record and index width
module lpt_node_ram (
  input  logic                           clk_i,
  input  logic                           re_i,
  input  logic [lpt_pkg::NODE_IDX_W-1:0] raddr_i,
  output lpt_pkg::node_t                 rdata_o,
  input  logic                           we_i,
  input  logic [lpt_pkg::NODE_IDX_W-1:0] waddr_i,
  input  lpt_pkg::node_t                 wdata_i
);

  lpt_pkg::node_t mem [lpt_pkg::NODE_COUNT];
  lpt_pkg::node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lpt_step.sv =====
// one trie level step: address bit, child select and pool space check
// depends on lpt_pkg for the node record and step result
module lpt_step (
  input  lpt_pkg::node_t                 parent_i,
  input  logic [lpt_pkg::ADDR_W-1:0]     address_i,
  input  logic [lpt_pkg::LVL_W-1:0]      len_i,
  input  logic [lpt_pkg::LVL_W-1:0]      level_i,
  input  logic [lpt_pkg::NODE_CNT_W-1:0] nodes_used_i,
  output lpt_pkg::step_t                 step_o
);

  logic [lpt_pkg::LVL_W-1:0] pos;
  logic [lpt_pkg::LVL_W-1:0] need;
  logic [lpt_pkg::SUM_W-1:0] total;

  always_comb begin
    pos   = lpt_pkg::LVL_W'(lpt_pkg::ADDR_BITS - 1) - level_i;
    need  = len_i - level_i;
    total = lpt_pkg::SUM_W'(need) + lpt_pkg::SUM_W'(nodes_used_i);
    step_o.bit_sel  = (level_i < lpt_pkg::LVL_W'(lpt_pkg::ADDR_BITS)) &&
                      address_i[pos[lpt_pkg::AIDX_W-1:0]];
    step_o.child    = step_o.bit_sel ? parent_i.right : parent_i.left;
    step_o.no_child = (step_o.child == '0);
    step_o.full     = (total > lpt_pkg::SUM_W'(lpt_pkg::NODE_COUNT));
  end

endmodule

// ===== rtl/ipv4_longest_prefix_trie.sv =====
// top level of the prefix trie: sequencer, root children, pool counter
// depends on lpt_pkg, lpt_step, lpt_node_ram and the assertion macros
//
// channel   direction  handshake               payload
// request   in         start && !busy          req_i  (lpt_pkg::req_t)
// result    out        done_o, one cycle       rsp_o  (lpt_pkg::rsp_t)
//
// one node memory read per trie level; the read port paces the walk
// lookup: a start step in idle, then one walk step per node visited, until the last address bit or a missing child
// insert: walks the existing levels, then links and allocates the missing nodes
// done_o is registered from the final step; busy is high while a walk runs
// reset empties the trie at once: root links are flip-flops, no clearing pass
// results cannot be stalled
`include "ipv4_longest_prefix_trie_macros.svh"
module ipv4_longest_prefix_trie (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lpt_pkg::req_t req_i,
  output logic          done_o,
  output lpt_pkg::rsp_t rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ALLOC
  } state_e;

  state_e                           state_q, state_d;
  lpt_pkg::op_e                     op_q, op_d;
  logic [lpt_pkg::ADDR_W-1:0]       addr_q, addr_d;
  logic [lpt_pkg::LVL_W-1:0]        len_q, len_d;
  logic [lpt_pkg::HOP_W-1:0]        hop_q, hop_d;
  logic [lpt_pkg::LVL_W-1:0]        lvl_q, lvl_d;
  logic [lpt_pkg::NODE_IDX_W-1:0]   node_q, node_d;
  logic                             hit_q, hit_d;
  logic [lpt_pkg::HOP_W-1:0]        found_q, found_d;
  logic [lpt_pkg::NODE_CNT_W-1:0]   used_q, used_d;
  logic [lpt_pkg::NODE_IDX_W-1:0]   root_l_q, root_l_d;
  logic [lpt_pkg::NODE_IDX_W-1:0]   root_r_q, root_r_d;
  logic                             done_q, done_d;
  lpt_pkg::rsp_t                    rsp_q, rsp_d;

  lpt_pkg::node_t                   rd_node;
  lpt_pkg::node_t                   wdata;
  lpt_pkg::node_t                   step_parent;
  lpt_pkg::step_t                   step;
  logic                             re, we;
  logic [lpt_pkg::NODE_IDX_W-1:0]   raddr, waddr;
  logic [lpt_pkg::ADDR_W-1:0]       step_addr;
  logic [lpt_pkg::LVL_W-1:0]        step_len, step_lvl, len_sat;
  logic [lpt_pkg::NODE_IDX_W-1:0]   new_idx, next_idx;
  logic [lpt_pkg::NODE_CNT_W-1:0]   used_inc;
  logic                             hit_v;
  logic [lpt_pkg::HOP_W-1:0]        found_v;

  lpt_step u_step (
    .parent_i     (step_parent),
    .address_i    (step_addr),
    .len_i        (step_len),
    .level_i      (step_lvl),
    .nodes_used_i (used_q),
    .step_o       (step)
  );

  lpt_node_ram u_ram (
    .clk_i   (clk_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_node),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  always_comb begin
    len_sat  = (req_i.prefix_len > lpt_pkg::LEN_W'(lpt_pkg::ADDR_BITS)) ?
               lpt_pkg::LVL_W'(lpt_pkg::ADDR_BITS) : lpt_pkg::LVL_W'(req_i.prefix_len);
    used_inc = used_q + lpt_pkg::NODE_CNT_W'(1);
    new_idx  = used_q[lpt_pkg::NODE_IDX_W-1:0];
    next_idx = used_inc[lpt_pkg::NODE_IDX_W-1:0];
    hit_v    = hit_q | rd_node.mark;
    found_v  = rd_node.mark ? rd_node.hop : found_q;

    step_parent = '0;
    step_addr   = addr_q;
    step_len    = len_q;
    step_lvl    = lvl_q + lpt_pkg::LVL_W'(1);
    case (state_q)
      ST_IDLE: begin
        step_parent.left  = root_l_q;
        step_parent.right = root_r_q;
        step_addr         = req_i.address;
        step_len          = len_sat;
        step_lvl          = '0;
      end
      ST_WALK: begin
        step_parent = rd_node;
      end
      default: begin
        step_parent = '0;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    addr_d   = addr_q;
    len_d    = len_q;
    hop_d    = hop_q;
    lvl_d    = lvl_q;
    node_d   = node_q;
    hit_d    = hit_q;
    found_d  = found_q;
    used_d   = used_q;
    root_l_d = root_l_q;
    root_r_d = root_r_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    re       = 1'b0;
    raddr    = step.child;
    we       = 1'b0;
    waddr    = node_q;
    wdata    = rd_node;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d    = req_i.op;
          addr_d  = req_i.address;
          len_d   = len_sat;
          hop_d   = req_i.next_hop;
          lvl_d   = '0;
          hit_d   = 1'b0;
          found_d = '0;
          node_d  = step.child;
          if (req_i.op == lpt_pkg::OP_LOOKUP) begin
            if (step.no_child) begin
              done_d = 1'b1;
              rsp_d  = '{status: lpt_pkg::STATUS_MISS, hop_out: '0};
            end else begin
              re      = 1'b1;
              state_d = ST_WALK;
            end
          end else if (len_sat == '0) begin
            done_d = 1'b1;
            rsp_d  = '{status: lpt_pkg::STATUS_OK, hop_out: '0};
          end else if (!step.no_child) begin
            re      = 1'b1;
            state_d = ST_WALK;
          end else if (step.full) begin
            done_d = 1'b1;
            rsp_d  = '{status: lpt_pkg::STATUS_FULL, hop_out: '0};
          end else begin
            if (step.bit_sel) begin
              root_r_d = new_idx;
            end else begin
              root_l_d = new_idx;
            end
            state_d = ST_ALLOC;
          end
        end
      end

      ST_WALK: begin
        if (op_q == lpt_pkg::OP_LOOKUP) begin
          hit_d   = hit_v;
          found_d = found_v;
          if ((lvl_q == lpt_pkg::LVL_W'(lpt_pkg::ADDR_BITS - 1)) || step.no_child) begin
            done_d  = 1'b1;
            rsp_d   = hit_v ? lpt_pkg::rsp_t'{status: lpt_pkg::STATUS_OK, hop_out: found_v} :
                              lpt_pkg::rsp_t'{status: lpt_pkg::STATUS_MISS, hop_out: '0};
            state_d = ST_IDLE;
          end else begin
            re     = 1'b1;
            node_d = step.child;
            lvl_d  = lvl_q + lpt_pkg::LVL_W'(1);
          end
        end else if (lvl_q == len_q - lpt_pkg::LVL_W'(1)) begin
          // prefix node already exists, only set its mark and next hop
          we         = 1'b1;
          wdata.mark = 1'b1;
          wdata.hop  = hop_q;
          done_d     = 1'b1;
          rsp_d      = '{status: lpt_pkg::STATUS_OK, hop_out: '0};
          state_d    = ST_IDLE;
        end else if (!step.no_child) begin
          re     = 1'b1;
          node_d = step.child;
          lvl_d  = lvl_q + lpt_pkg::LVL_W'(1);
        end else if (step.full) begin
          done_d  = 1'b1;
          rsp_d   = '{status: lpt_pkg::STATUS_FULL, hop_out: '0};
          state_d = ST_IDLE;
        end else begin
          // link the first new node into the deepest existing node
          we = 1'b1;
          if (step.bit_sel) begin
            wdata.right = new_idx;
          end else begin
            wdata.left = new_idx;
          end
          lvl_d   = lvl_q + lpt_pkg::LVL_W'(1);
          state_d = ST_ALLOC;
        end
      end

      ST_ALLOC: begin
        we     = 1'b1;
        waddr  = new_idx;
        wdata  = '0;
        used_d = used_inc;
        if (lvl_q == len_q - lpt_pkg::LVL_W'(1)) begin
          wdata.mark = 1'b1;
          wdata.hop  = hop_q;
          done_d     = 1'b1;
          rsp_d      = '{status: lpt_pkg::STATUS_OK, hop_out: '0};
          state_d    = ST_IDLE;
        end else begin
          if (step.bit_sel) begin
            wdata.right = next_idx;
          end else begin
            wdata.left = next_idx;
          end
          lvl_d = lvl_q + lpt_pkg::LVL_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= lpt_pkg::NODE_CNT_W'(1);
      root_l_q <= '0;
      root_r_q <= '0;
      done_q   <= 1'b0;
      op_q     <= lpt_pkg::OP_INSERT;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      root_l_q <= root_l_d;
      root_r_q <= root_r_d;
      done_q   <= done_d;
      op_q     <= op_d;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    len_q   <= len_d;
    hop_q   <= hop_d;
    lvl_q   <= lvl_d;
    node_q  <= node_d;
    found_q <= found_d;
    rsp_q   <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `LPT_ASSERT(a_used_bound, used_q <= lpt_pkg::NODE_CNT_W'(lpt_pkg::NODE_COUNT), "pool overrun")
  `LPT_ASSERT(a_done_idle, done_o |-> !busy, "result while busy")
  `LPT_ASSERT(a_full_no_alloc, (done_o && rsp_o.status == lpt_pkg::STATUS_FULL) |-> $stable(used_q), "full insert allocated")
  `LPT_ASSERT(a_hop_zero, (done_o && rsp_o.status != lpt_pkg::STATUS_OK) |-> (rsp_o.hop_out == '0), "nonzero hop on failure")

endmodule
